/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
// Each macro expands to one labeled concurrent assertion on clk, held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wfb64_pkg.sv */
// ----------------------------------------------------------------------------
// wfb64_pkg
// Types and constants of the wide float to binary64 rounding converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfb64_pkg;

  // Rounding mode register codes
  typedef enum logic [1:0] {
    RND_NEAR_EVEN = 2'd0,
    RND_DOWN      = 2'd1,
    RND_UP        = 2'd2,
    RND_ZERO      = 2'd3
  } rnd_mode_t;

  localparam int unsigned SIG_W    = 64;
  localparam int unsigned EXP_W    = 16;
  localparam int unsigned FRAC_W   = 52;
  localparam int unsigned BEXP_W   = 11;
  localparam int unsigned SHF_W    = 7;

  // Normal range shift and full-shift clamp
  localparam logic [SHF_W-1:0] SHF_NORMAL = 7'd11;
  localparam logic [SHF_W-1:0] SHF_MAX    = 7'd65;

  localparam logic signed [EXP_W-1:0] EXP_MAX_NORM = 16'sd1023;
  localparam logic signed [EXP_W-1:0] EXP_MIN_NORM = -16'sd1022;
  localparam logic signed [16:0]      SUB_BIAS     = 17'sd1011;
  localparam logic [BEXP_W-1:0]       EXP_BIAS     = 11'd1023;
  localparam logic [BEXP_W-1:0]       BEXP_TOP     = 11'd2046;

  localparam logic [62:0] INF_MAG    = 63'h7FF0000000000000;
  localparam logic [62:0] MAXFIN_MAG = 63'h7FEFFFFFFFFFFFFF;

endpackage

/* rtl/wide_float_to_binary64_round_top.sv */
// ----------------------------------------------------------------------------
// wide_float_to_binary64_round_top
// Rounds a signed wide float (256-bit significand) to a binary64 pattern.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     in_valid / in_ready       sign, exponent, sig_word3..sig_word0
// output    out_valid / out_ready     result_bits, underflow_flag, overflow_flag
// config    rounding_mode_we          rounding_mode_wdata
//
// Three register stages: decode, alignment shift, round and pack.
// One request per cycle while the output is not stalled; a request passes
// the decode, shift and round-and-pack registers in turn before out_valid rises.
// Ready flows back stage by stage, so a stall holds every occupied stage
// and empty stages keep filling.
// rst is synchronous and clears the stage valid bits and the mode register.
`timescale 1ns / 1ps

module wide_float_to_binary64_round_top
  import wfb64_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rounding_mode_we,
  input  logic [1:0]              rounding_mode_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    sign,
  input  logic signed [EXP_W-1:0] exponent,
  input  logic [SIG_W-1:0]        sig_word3,
  input  logic [SIG_W-1:0]        sig_word2,
  input  logic [SIG_W-1:0]        sig_word1,
  input  logic [SIG_W-1:0]        sig_word0,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             result_bits,
  output logic                    underflow_flag,
  output logic                    overflow_flag
);

`include "assert_macros.svh"

  rnd_mode_t mode;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= RND_NEAR_EVEN;
    end else if (rounding_mode_we) begin
      mode <= rnd_mode_t'(rounding_mode_wdata);
    end
  end

  // Stage handshake chain
  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v3;

  // ---------------- Stage 1: decode exponent ----------------
  logic                    s1_sign, s1_pre_ovf, s1_norm, s1_low_nz;
  rnd_mode_t               s1_mode;
  logic [BEXP_W-1:0]       s1_bexp;
  logic [SHF_W-1:0]        s1_shf;
  logic [SIG_W-1:0]        s1_hh;

  logic signed [16:0]      sub_shf;
  logic [SHF_W-1:0]        shf_d;
  logic                    norm_d;

  always_comb begin
    norm_d  = (exponent >= EXP_MIN_NORM);
    sub_shf = -(17'(exponent) + SUB_BIAS);
    if (norm_d) begin
      shf_d = SHF_NORMAL;
    end else if (sub_shf > 17'sd65) begin
      shf_d = SHF_MAX;
    end else begin
      shf_d = sub_shf[SHF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_sign    <= sign;
      s1_mode    <= mode;
      s1_pre_ovf <= (exponent > EXP_MAX_NORM);
      s1_norm    <= norm_d;
      s1_bexp    <= exponent[BEXP_W-1:0] + EXP_BIAS;
      s1_shf     <= shf_d;
      s1_hh      <= {1'b1, sig_word3[SIG_W-2:0]};
      s1_low_nz  <= |{sig_word2, sig_word1, sig_word0};
    end
  end

  // ---------------- Stage 2: alignment shift ----------------
  logic                    s2_sign, s2_pre_ovf, s2_norm, s2_guard, s2_sticky;
  rnd_mode_t               s2_mode;
  logic [BEXP_W-1:0]       s2_bexp;
  logic [FRAC_W:0]         s2_hi;

  logic [2*SIG_W-1:0]      ext;
  assign ext = {s1_hh, {SIG_W{1'b0}}} >> s1_shf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2_sign    <= s1_sign;
      s2_mode    <= s1_mode;
      s2_pre_ovf <= s1_pre_ovf;
      s2_norm    <= s1_norm;
      s2_bexp    <= s1_bexp;
      s2_hi      <= ext[SIG_W+FRAC_W:SIG_W];
      s2_guard   <= ext[SIG_W-1];
      s2_sticky  <= (|ext[SIG_W-2:0]) || s1_low_nz;
    end
  end

  // ---------------- Stage 3: round and pack ----------------
  logic              inc, carry, ovf, uf, to_inf;
  logic [FRAC_W+1:0] rnd;
  logic [62:0]       mag;

  always_comb begin
    unique case (s2_mode)
      RND_NEAR_EVEN: inc = s2_guard && (s2_sticky || s2_hi[0]);
      RND_DOWN:      inc = s2_sign && (s2_guard || s2_sticky);
      RND_UP:        inc = !s2_sign && (s2_guard || s2_sticky);
      RND_ZERO:      inc = 1'b0;
      default:       inc = 1'b0;
    endcase
    rnd    = {1'b0, s2_hi} + (FRAC_W+2)'(inc);
    carry  = rnd[FRAC_W+1];
    ovf    = s2_pre_ovf || (s2_norm && carry && (s2_bexp == BEXP_TOP));
    uf     = !s2_pre_ovf && !s2_norm && !rnd[FRAC_W];
    to_inf = (s2_mode == RND_NEAR_EVEN) || ((s2_mode == RND_DOWN) && s2_sign)
             || ((s2_mode == RND_UP) && !s2_sign);
    if (ovf) begin
      mag = to_inf ? INF_MAG : MAXFIN_MAG;
    end else if (s2_norm) begin
      mag = carry ? {s2_bexp + 11'd1, {FRAC_W{1'b0}}} : {s2_bexp, rnd[FRAC_W-1:0]};
    end else begin
      mag = {9'd0, rnd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      result_bits    <= {s2_sign, mag};
      underflow_flag <= uf;
      overflow_flag  <= ovf;
    end
  end

  // ---------------- Checks ----------------
  `ASSERT_ALWAYS(a_flags_excl, !(v3 && underflow_flag && overflow_flag),
                 "underflow and overflow both set")
  `ASSERT_IMPLY(a_ovf_pattern, v3 && overflow_flag,
                (result_bits[62:0] == INF_MAG) || (result_bits[62:0] == MAXFIN_MAG),
                "overflow result is not inf or max finite")
  `ASSERT_IMPLY(a_uf_exp_zero, v3 && underflow_flag, result_bits[62:52] == 11'd0,
                "underflow result has nonzero exponent")
  `ASSERT_NEXT(a_s2_hold, v2 && !adv2, v2, "stage 2 request lost under stall")

endmodule

/* bench/wide_float_to_binary64_round_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_float_to_binary64_round_top_tb
// Drives wide float requests through the binary64 rounding converter and
// compares every result against an in-bench rounding predictor, across all
// rounding modes, exponent ranges, carries, overflow and deep underflow.
// ----------------------------------------------------------------------------

module wide_float_to_binary64_round_top_tb;
  import wfb64_pkg::*;

  typedef struct packed {
    logic [63:0] bits;
    logic        uf;
    logic        of;
  } b64_res_t;

  logic        clk;
  logic        rst;
  logic        rounding_mode_we;
  logic [1:0]  rounding_mode_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        sign;
  logic signed [15:0] exponent;
  logic [63:0] sig_word3, sig_word2, sig_word1, sig_word0;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_bits;
  logic        underflow_flag;
  logic        overflow_flag;

  rnd_mode_t   cur_mode;
  b64_res_t    pending_results[$];
  int          err_count;
  int          idle_cycles;
  bit          rx_random_stall;
  bit          rx_hold;
  bit          tx_random_gap;

  wide_float_to_binary64_round_top uut (
    .clk(clk), .rst(rst),
    .rounding_mode_we(rounding_mode_we), .rounding_mode_wdata(rounding_mode_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .sign(sign), .exponent(exponent),
    .sig_word3(sig_word3), .sig_word2(sig_word2),
    .sig_word1(sig_word1), .sig_word0(sig_word0),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_bits(result_bits), .underflow_flag(underflow_flag),
    .overflow_flag(overflow_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounding predictor: one wide float to a binary64 pattern and flags
  function automatic b64_res_t round_to_b64(logic s, logic signed [15:0] e_in,
                                            logic [63:0] w3, logic [63:0] w2,
                                            logic [63:0] w1, logic [63:0] w0,
                                            rnd_mode_t m);
    b64_res_t r;
    int e;
    int sh;
    logic [63:0] top;
    logic [64:0] mant;
    logic grd, stk, carry_in, ovf, to_inf;
    r = '0;
    e = e_in;
    top = w3 | 64'h8000_0000_0000_0000;
    ovf = 1'b0;
    if (e > 1023) begin
      ovf = 1'b1;
    end else begin
      sh = (e >= -1022) ? 11 : -(e + 1011);
      mant = (sh < 64) ? {1'b0, top >> sh} : 65'd0;
      if (sh - 1 < 64) begin
        grd = top[sh-1];
        stk = ((top & ((64'd1 << (sh - 1)) - 64'd1)) != 0) || ((w2 | w1 | w0) != 0);
      end else begin
        grd = 1'b0;
        stk = 1'b1;
      end
      case (m)
        RND_NEAR_EVEN: carry_in = grd & (stk | mant[0]);
        RND_DOWN:      carry_in = s & (grd | stk);
        RND_UP:        carry_in = ~s & (grd | stk);
        default:       carry_in = 1'b0;
      endcase
      mant = mant + carry_in;
      if (e >= -1022) begin
        if (mant[53]) begin
          mant = mant >> 1;
          e = e + 1;
        end
        if (e > 1023) ovf = 1'b1;
        else r.bits = {1'b0, 11'(e + 1023), mant[51:0]};
      end else begin
        r.bits = mant[63:0];
        r.uf = (mant < 65'h10_0000_0000_0000);
      end
    end
    if (ovf) begin
      to_inf = (m == RND_NEAR_EVEN) || (m == RND_DOWN && s) || (m == RND_UP && !s);
      r.bits = to_inf ? {1'b0, INF_MAG} : {1'b0, MAXFIN_MAG};
      r.of = 1'b1;
    end
    r.bits[63] = s;
    return r;
  endfunction

  // Send one request and queue its expected result; valid stays up afterwards
  task automatic send_request(logic s, logic signed [15:0] e, logic [63:0] w3,
                              logic [63:0] w2, logic [63:0] w1, logic [63:0] w0);
    while (tx_random_gap && ($urandom_range(99) < 35)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sign      <= s;
    exponent  <= e;
    sig_word3 <= w3;
    sig_word2 <= w2;
    sig_word1 <= w1;
    sig_word0 <= w0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(round_to_b64(s, e, w3, w2, w1, w0, cur_mode));
  endtask

  // Write the mode register once the pipeline has drained
  task automatic set_mode(rnd_mode_t m);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    rounding_mode_we    <= 1'b1;
    rounding_mode_wdata <= m;
    @(posedge clk);
    rounding_mode_we <= 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random exponent weighted toward the interesting boundaries
  function automatic logic signed [15:0] pick_exponent();
    case ($urandom_range(5))
      0: return 16'($urandom_range(2100) - 1050);
      1: return 16'($urandom_range(10) + 1018);
      2: return 16'(-1022 - $urandom_range(12));
      3: return 16'(-1074 - $urandom_range(70) + 10);
      4: return 16'($urandom());
      default: return 16'(-1022 - $urandom_range(60));
    endcase
  endfunction

  function automatic logic [63:0] pick_top();
    case ($urandom_range(3))
      0: return 64'hFFFF_FFFF_FFFF_FFFF << $urandom_range(12);
      1: return 64'h8000_0000_0000_0000 | (64'd1 << $urandom_range(12));
      default: return rand64();
    endcase
  endfunction

  // Directed corners: field extremes, carries, overflow and underflow
  task automatic test_directed();
    rnd_mode_t m;
    for (int i = 0; i < 4; i++) begin
      m = rnd_mode_t'(i);
      set_mode(m);
      send_request(1'b0, 16'sd0, 64'h8000_0000_0000_0000, 0, 0, 0);
      send_request(1'b1, 16'sd1023, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1);
      send_request(1'b0, 16'sd1023, 64'hFFFF_FFFF_FFFF_F800, 0, 0, 0);
      send_request(1'b1, 16'sh7FFF, 64'h0, 0, 0, 0);
      send_request(1'b0, 16'sh8000, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, '1);
      send_request(1'b1, -16'sd1023, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
      send_request(1'b0, -16'sd1074, 64'h8000_0000_0000_0000, 0, 0, 0);
      send_request(1'b1, -16'sd1075, 64'h8000_0000_0000_0000, 0, 0, 0);
      send_request(1'b0, -16'sd1140, 64'h8000_0000_0000_0001, 0, 1, 0);
      send_request(1'b1, 16'sd5, 64'h7FFF_FFFF_FFFF_FC00, 0, 0, 0);
    end
  endtask

  // Random requests per mode, mostly near the edges of the format
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 0) set_mode(rnd_mode_t'($urandom_range(3)));
      send_request(1'($urandom()), pick_exponent(), pick_top(),
                   ($urandom_range(2) == 0) ? 64'd0 : rand64(),
                   ($urandom_range(2) == 0) ? 64'd0 : rand64(),
                   ($urandom_range(2) == 0) ? 64'd0 : rand64());
    end
  endtask

  // Back-pressure: receiver holds off while requests keep coming
  task automatic test_backpressure();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    rx_hold <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        rx_hold <= 1'b0;
      end
      test_random(40);
    join
  endtask

  // Streaming with random gaps and stalls turned off on both sides
  task automatic test_streaming();
    tx_random_gap = 1'b0;
    rx_random_stall <= 1'b0;
    test_random(150);
    tx_random_gap = 1'b1;
    rx_random_stall <= 1'b1;
  endtask

  // Receiver ready
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !rx_hold && !(rx_random_stall && ($urandom_range(99) < 35));
  end

  // Result checker
  always @(posedge clk) begin
    b64_res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%t unexpected result %h", $realtime, result_bits);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_bits !== exp_r.bits) begin
          $display("%t result_bits exp %h got %h", $realtime, exp_r.bits, result_bits);
          err_count++;
        end
        if (underflow_flag !== exp_r.uf) begin
          $display("%t underflow_flag exp %b got %b", $realtime, exp_r.uf, underflow_flag);
          err_count++;
        end
        if (overflow_flag !== exp_r.of) begin
          $display("%t overflow_flag exp %b got %b", $realtime, exp_r.of, overflow_flag);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sign = 1'b0;
    exponent = '0;
    sig_word3 = '0;
    sig_word2 = '0;
    sig_word1 = '0;
    sig_word0 = '0;
    rounding_mode_we = 1'b0;
    rounding_mode_wdata = '0;
    err_count = 0;
    idle_cycles = 0;
    cur_mode = RND_NEAR_EVEN;
    rx_random_stall = 1'b1;
    rx_hold = 1'b0;
    tx_random_gap = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_streaming();
    test_random(720);
    set_mode(RND_NEAR_EVEN);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
